FILE: src/ost_pkg.sv
// Shared types for the ordered sequence table: operation codes and cell commands.
package ost_pkg;

    typedef enum logic [2:0] {
        OP_INSERT_AT = 3'd0,
        OP_SORTED    = 3'd1,
        OP_ERASE_AT  = 3'd2,
        OP_REMOVE    = 3'd3,
        OP_GET       = 3'd4,
        OP_SET       = 3'd5,
        OP_FIND      = 3'd6,
        OP_UNUSED    = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } t_cell_op;

    localparam logic [7:0] NO_INDEX = 8'hFF;

endpackage

FILE: src/ordered_sequence_table.sv
// Ordered sequence table top level: control sequencer around a chain of entry cells.
//
// The table keeps up to DEPTH values in a row of cells, entry k in cell k. Insert at a
// position and erase at a position finish without walking the list, since every cell
// shifts to or from its neighbour at once. Sorted insert, remove value, get, set and
// find walk the list by rotating it: each step moves every live entry down one cell
// and sends the head to the back, so after count steps the list is in its original
// order again and every entry has been seen at the head. Remove drops matching heads
// instead of rotating them, which compacts the rest in order. The walking operations
// rotate the cell chain one entry per cycle. One item is worked on at a time; a new
// item is taken while the previous result still waits in the output register. Values
// are taken modulo 2^ITEM_WIDTH. Reading an entry at or above the count never
// happens, so cells need no reset.
module ordered_sequence_table #(
    parameter int DEPTH      = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [6:0]  i_position,
    input  logic [31:0] i_item_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ok,
    output logic [7:0]  o_result_index,
    output logic [31:0] o_read_value,
    output logic [6:0]  o_removed_count,
    output logic [6:0]  o_entry_count,
    output logic        o_is_empty
);
    import ost_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_INSERT,
        ST_FINISH
    } t_state;

    t_state                r_state;
    t_opcode               r_op;
    logic [6:0]            r_pos;
    logic [ITEM_WIDTH-1:0] r_val;
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         r_k;
    logic [CW-1:0]         r_steps;
    logic                  r_found;
    logic                  r_has_idx;
    logic [CW-1:0]         r_idx;
    logic                  r_okf;
    logic [ITEM_WIDTH-1:0] r_rd;
    logic [CW-1:0]         r_removed;

    logic                  r_out_valid;
    logic                  r_ok;
    logic [7:0]            r_result_index;
    logic [31:0]           r_read_value;
    logic [6:0]            r_removed_count;
    logic [6:0]            r_entry_count;
    logic                  r_is_empty;

    t_cell_op              w_cop;
    logic [IW-1:0]         w_cpos;
    logic [IW-1:0]         w_last;
    logic [ITEM_WIDTH-1:0] w_cdata;
    logic [ITEM_WIDTH-1:0] w_head;

    logic [31:0]           w_pos32;
    logic [31:0]           w_cnt32;
    logic                  w_pos_le_cnt;
    logic                  w_pos_lt_cnt;
    logic                  w_full;
    logic                  w_ins_ok;
    logic                  w_match;
    logic                  w_le;
    logic                  w_at_pos;
    logic                  w_last_step;
    logic [CW-1:0]         w_ins_pos;
    logic [63:0]           w_val64;
    logic                  w_out_free;

    assign w_val64      = {32'd0, i_item_value};
    assign w_pos32      = {25'd0, r_pos};
    assign w_cnt32      = 32'(r_cnt);
    assign w_pos_le_cnt = (w_pos32 <= w_cnt32);
    assign w_pos_lt_cnt = (w_pos32 < w_cnt32);
    assign w_full       = (w_cnt32 == 32'(DEPTH));
    assign w_ins_ok     = w_pos_le_cnt && !w_full;
    assign w_match      = (w_head == r_val);
    assign w_le         = (r_val <= w_head);
    assign w_at_pos     = (32'(r_k) == w_pos32);
    assign w_last_step  = ((r_k + CW'(1)) == r_steps);
    assign w_ins_pos    = r_found ? r_idx : r_cnt;
    assign w_last       = IW'(r_cnt - CW'(1));
    assign w_out_free   = !r_out_valid || i_out_ready;

    // cell command for this cycle
    always_comb begin
        w_cop   = CELL_HOLD;
        w_cpos  = r_pos[IW-1:0] & {IW{1'b1}};
        w_cdata = r_val;
        unique case (r_state)
            ST_DECIDE: begin
                w_cpos = IW'(w_pos32);
                if (r_op == OP_INSERT_AT && w_ins_ok) begin
                    w_cop = CELL_INS;
                end else if (r_op == OP_ERASE_AT && w_pos_lt_cnt) begin
                    w_cop = CELL_DEL;
                end
            end
            ST_SCAN: begin
                w_cpos  = '0;
                w_cop   = CELL_ROT;
                w_cdata = w_head;
                if (r_op == OP_REMOVE && w_match) begin
                    w_cop = CELL_DEL;
                end else if (r_op == OP_SET && w_at_pos) begin
                    w_cdata = r_val;
                end
            end
            ST_INSERT: begin
                w_cop  = CELL_INS;
                w_cpos = IW'(w_ins_pos);
            end
            default: begin
                w_cop = CELL_HOLD;
            end
        endcase
    end

    ost_chain #(
        .DEPTH      (DEPTH),
        .IW         (IW),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_chain (
        .i_clk  (i_clk),
        .i_op   (w_cop),
        .i_pos  (w_cpos),
        .i_last (w_last),
        .i_data (w_cdata),
        .o_head (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once it is taken, unless a new one loads now
            if (r_out_valid && i_out_ready && r_state != ST_FINISH) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_op      <= t_opcode'(i_opcode);
                        r_pos     <= i_position;
                        r_val     <= w_val64[ITEM_WIDTH-1:0];
                        r_state   <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_k       <= '0;
                    r_steps   <= r_cnt;
                    r_found   <= 1'b0;
                    r_has_idx <= (r_op == OP_INSERT_AT) && w_ins_ok;
                    r_idx     <= CW'(w_pos32);
                    r_rd      <= '0;
                    r_removed <= '0;
                    case (r_op)
                        OP_INSERT_AT: begin
                            r_okf   <= w_ins_ok;
                            r_state <= ST_FINISH;
                            if (w_ins_ok) begin
                                r_cnt <= r_cnt + CW'(1);
                            end
                        end
                        OP_SORTED: begin
                            r_okf <= 1'b0;
                            if (w_full) begin
                                r_state <= ST_FINISH;
                            end else begin
                                r_state <= (r_cnt == '0) ? ST_INSERT : ST_SCAN;
                            end
                        end
                        OP_ERASE_AT: begin
                            r_okf   <= w_pos_lt_cnt;
                            r_state <= ST_FINISH;
                            if (w_pos_lt_cnt) begin
                                r_cnt <= r_cnt - CW'(1);
                            end
                        end
                        OP_REMOVE, OP_FIND: begin
                            r_okf   <= 1'b1;
                            r_state <= (r_cnt != '0) ? ST_SCAN : ST_FINISH;
                        end
                        OP_GET, OP_SET: begin
                            r_okf   <= w_pos_lt_cnt;
                            r_state <= w_pos_lt_cnt ? ST_SCAN : ST_FINISH;
                        end
                        default: begin
                            r_okf   <= 1'b0;
                            r_state <= ST_FINISH;
                        end
                    endcase
                end
                ST_SCAN: begin
                    r_k <= r_k + CW'(1);
                    case (r_op)
                        OP_REMOVE: begin
                            if (w_match) begin
                                r_cnt     <= r_cnt - CW'(1);
                                r_removed <= r_removed + CW'(1);
                            end
                        end
                        OP_GET: begin
                            if (w_at_pos) begin
                                r_rd <= w_head;
                            end
                        end
                        OP_FIND: begin
                            if (!r_found && w_match) begin
                                r_found   <= 1'b1;
                                r_has_idx <= 1'b1;
                                r_idx     <= r_k;
                            end
                        end
                        OP_SORTED: begin
                            if (!r_found && w_le) begin
                                r_found <= 1'b1;
                                r_idx   <= r_k;
                            end
                        end
                        default: begin
                            r_rd <= r_rd;
                        end
                    endcase
                    if (w_last_step) begin
                        r_state <= (r_op == OP_SORTED) ? ST_INSERT : ST_FINISH;
                    end
                end
                ST_INSERT: begin
                    r_cnt     <= r_cnt + CW'(1);
                    r_okf     <= 1'b1;
                    r_has_idx <= 1'b1;
                    r_idx     <= w_ins_pos;
                    r_state   <= ST_FINISH;
                end
                ST_FINISH: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_out_valid     <= 1'b1;
                        r_ok            <= r_okf;
                        r_result_index  <= r_has_idx ? 8'(32'(r_idx)) : NO_INDEX;
                        r_read_value    <= 32'({32'd0, r_rd} & 64'hFFFF_FFFF);
                        r_removed_count <= 7'(32'(r_removed));
                        r_entry_count   <= 7'(32'(r_cnt));
                        r_is_empty      <= (r_cnt == '0);
                        r_state         <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_ok;
    assign o_result_index  = r_result_index;
    assign o_read_value    = r_read_value;
    assign o_removed_count = r_removed_count;
    assign o_entry_count   = r_entry_count;
    assign o_is_empty      = r_is_empty;

endmodule

FILE: src/ost_cell.sv
// One storage cell of the table chain: holds one entry and loads from a neighbour.
module ost_cell #(
    parameter int INDEX      = 0,
    parameter int IW         = 6,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                  i_clk,
    input  ost_pkg::t_cell_op     i_op,
    input  logic [IW-1:0]         i_pos,
    input  logic [IW-1:0]         i_last,
    input  logic [ITEM_WIDTH-1:0] i_data,
    input  logic [ITEM_WIDTH-1:0] i_left,
    input  logic [ITEM_WIDTH-1:0] i_right,
    output logic [ITEM_WIDTH-1:0] o_value
);
    import ost_pkg::*;

    localparam logic [IW-1:0] MY_IDX = INDEX[IW-1:0];

    logic [ITEM_WIDTH-1:0] r_value;
    logic [ITEM_WIDTH-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_op)
            CELL_INS: begin
                // open a gap: shift up above the position, take the new item at it
                if (MY_IDX > i_pos) begin
                    n_value = i_left;
                end else if (MY_IDX == i_pos) begin
                    n_value = i_data;
                end
            end
            CELL_DEL: begin
                if (MY_IDX >= i_pos) begin
                    n_value = i_right;
                end
            end
            CELL_ROT: begin
                // move down one place, the last live entry takes the head
                if (MY_IDX < i_last) begin
                    n_value = i_right;
                end else if (MY_IDX == i_last) begin
                    n_value = i_data;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

FILE: src/ost_chain.sv
// Row of table cells linked to their neighbours; exposes the head entry.
module ost_chain #(
    parameter int DEPTH      = 64,
    parameter int IW         = 6,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                  i_clk,
    input  ost_pkg::t_cell_op     i_op,
    input  logic [IW-1:0]         i_pos,
    input  logic [IW-1:0]         i_last,
    input  logic [ITEM_WIDTH-1:0] i_data,
    output logic [ITEM_WIDTH-1:0] o_head
);
    import ost_pkg::*;

    logic [ITEM_WIDTH-1:0] w_value [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ITEM_WIDTH-1:0] w_left;
        logic [ITEM_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = i_data;
        end else begin : g_mid_l
            assign w_left = w_value[g-1];
        end
        if (g == DEPTH - 1) begin : g_end
            assign w_right = w_value[g];
        end else begin : g_mid_r
            assign w_right = w_value[g+1];
        end
        ost_cell #(
            .INDEX      (g),
            .IW         (IW),
            .ITEM_WIDTH (ITEM_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (i_op),
            .i_pos   (i_pos),
            .i_last  (i_last),
            .i_data  (i_data),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_value[g])
        );
    end

    assign o_head = w_value[0];

endmodule
